>>> design/tssg_pkg.sv
// ----------------------------------------------------------------------------
// tssg_pkg
// shared types and constants of the triangle scanline span generator
// ----------------------------------------------------------------------------
package tssg_pkg;

    localparam int CB    = 11;                  // coordinate bits
    localparam int COL_W = 32;                  // packed rgba colour bits
    localparam int CNT_W = $clog2(CB);          // divider step counter bits

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // one queued item: a step carries don't-care vertex fields
    typedef struct packed {
        logic             op;
        logic [CB-1:0]    lx;
        logic [CB-1:0]    ly;
        logic [CB-1:0]    mx;
        logic [CB-1:0]    my;
        logic [CB-1:0]    hx;
        logic [CB-1:0]    hy;
        logic [COL_W-1:0] colour;
    } t_cmd;

endpackage

>>> design/tssg_front.sv
// ----------------------------------------------------------------------------
// tssg_front
// takes input items and sorts load vertices by y (stable) into a queue entry
// ----------------------------------------------------------------------------
module tssg_front (
    input  logic                     i_operation,
    input  logic [tssg_pkg::CB-1:0]  i_ax,
    input  logic [tssg_pkg::CB-1:0]  i_ay,
    input  logic [tssg_pkg::CB-1:0]  i_bx,
    input  logic [tssg_pkg::CB-1:0]  i_by,
    input  logic [tssg_pkg::CB-1:0]  i_cx,
    input  logic [tssg_pkg::CB-1:0]  i_cy,
    input  logic [tssg_pkg::COL_W-1:0] i_colour_a,
    input  logic [tssg_pkg::COL_W-1:0] i_colour_b,
    input  logic [tssg_pkg::COL_W-1:0] i_colour_c,
    output tssg_pkg::t_cmd           o_cmd
);
    import tssg_pkg::*;

    typedef struct packed {
        logic [CB-1:0]    x;
        logic [CB-1:0]    y;
        logic [COL_W-1:0] c;
    } t_vtx;

    t_vtx v0, v1, v2, s0, s1, s2, t1, t2, u0, u1;

    // adjacent compare-swap with strict greater keeps equal rows in input order
    always_comb begin
        v0 = '{x: i_ax, y: i_ay, c: i_colour_a};
        v1 = '{x: i_bx, y: i_by, c: i_colour_b};
        v2 = '{x: i_cx, y: i_cy, c: i_colour_c};
        if (v0.y > v1.y) begin
            s0 = v1; s1 = v0;
        end else begin
            s0 = v0; s1 = v1;
        end
        s2 = v2;
        if (s1.y > s2.y) begin
            t1 = s2; t2 = s1;
        end else begin
            t1 = s1; t2 = s2;
        end
        if (s0.y > t1.y) begin
            u0 = t1; u1 = s0;
        end else begin
            u0 = s0; u1 = t1;
        end
        o_cmd.op     = i_operation;
        o_cmd.lx     = u0.x;
        o_cmd.ly     = u0.y;
        o_cmd.mx     = u1.x;
        o_cmd.my     = u1.y;
        o_cmd.hx     = t2.x;
        o_cmd.hy     = t2.y;
        o_cmd.colour = t2.c;
    end

endmodule

>>> design/tssg_queue.sv
// ----------------------------------------------------------------------------
// tssg_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module tssg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tssg_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_avail,
    output tssg_pkg::t_cmd o_cmd
);
    import tssg_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> design/tssg_back.sv
// ----------------------------------------------------------------------------
// tssg_back
// triangle state, edge interpolation with a shared iterative divider, output
// ----------------------------------------------------------------------------
module tssg_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_avail,
    input  tssg_pkg::t_cmd             i_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tssg_pkg::CB-1:0]    o_span_row,
    output logic [tssg_pkg::CB-1:0]    o_span_left,
    output logic [tssg_pkg::CB-1:0]    o_span_right,
    output logic [tssg_pkg::COL_W-1:0] o_span_colour,
    output logic                       o_last_span
);
    import tssg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SEL  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       r_st;
    logic             r_busy, r_edge, r_neg, r_horiz, r_ov;
    logic [CB-1:0]    r_lx, r_ly, r_mx, r_my, r_hx, r_hy, r_row;
    logic [COL_W-1:0] r_col;
    logic [CB-1:0]    r_x0, r_dxa, r_t, r_den, r_low, r_left, r_right;
    logic [CB:0]      r_rem;
    logic [CNT_W-1:0] r_cnt;

    logic [CB-1:0]    x0, y0, x1, y1, quo, q, xv;
    logic [CB:0]      dx, rem2;
    logic [2*CB-1:0]  prod;
    logic             take_out;

    // edge selection: long edge first, then the active short edge
    always_comb begin
        if (!r_edge) begin
            x0 = r_lx; y0 = r_ly; x1 = r_hx; y1 = r_hy;
        end else if (r_my == r_hy || r_my > r_row) begin
            x0 = r_lx; y0 = r_ly; x1 = r_mx; y1 = r_my;
        end else begin
            x0 = r_mx; y0 = r_my; x1 = r_hx; y1 = r_hy;
        end
        dx   = {1'b0, x1} - {1'b0, x0};
        prod = r_dxa * r_t;
        rem2 = {r_rem[CB-1:0], r_low[CB-1]};
        quo  = r_low;
        q    = r_neg ? (~(quo + {{(CB-1){1'b0}}, (r_rem != '0)}) + 1'b1) : quo;
        xv   = r_horiz ? r_x0 : (r_x0 + q);
    end

    assign take_out = (r_st == S_OUT) && (!r_ov || !i_stall);
    assign o_pop    = (r_st == S_IDLE) && i_avail;
    assign o_valid  = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_edge <= 1'b0;
            r_lx <= '0; r_ly <= '0; r_mx <= '0; r_my <= '0;
            r_hx <= '0; r_hy <= '0; r_row <= '0; r_col <= '0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_avail) begin
                        if (i_cmd.op == OP_LOAD) begin
                            r_lx <= i_cmd.lx; r_ly <= i_cmd.ly;
                            r_mx <= i_cmd.mx; r_my <= i_cmd.my;
                            r_hx <= i_cmd.hx; r_hy <= i_cmd.hy;
                            r_col  <= i_cmd.colour;
                            r_row  <= i_cmd.ly;
                            r_busy <= 1'b1;
                        end else if (r_busy) begin
                            r_edge <= 1'b0;
                            r_st   <= S_SEL;
                        end
                    end
                end
                S_SEL: begin
                    r_x0    <= x0;
                    r_neg   <= dx[CB];
                    r_dxa   <= dx[CB] ? CB'(-dx) : dx[CB-1:0];
                    r_t     <= r_row - y0;
                    r_den   <= y1 - y0;
                    r_horiz <= (y1 == y0);
                    r_st    <= S_MUL;
                end
                S_MUL: begin
                    r_rem <= {1'b0, prod[2*CB-1:CB]};
                    r_low <= prod[CB-1:0];
                    r_cnt <= '0;
                    r_st  <= S_DIV;
                end
                S_DIV: begin
                    // one restoring step; quotient bits shift in from the right
                    if (rem2 >= {1'b0, r_den}) begin
                        r_rem <= rem2 - {1'b0, r_den};
                        r_low <= {r_low[CB-2:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_low <= {r_low[CB-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CB-1)) begin
                        r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_edge) begin
                        r_right <= xv;
                        r_edge  <= 1'b1;
                        r_st    <= S_SEL;
                    end else begin
                        r_left <= xv;
                        r_st   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (take_out) begin
                        r_ov <= 1'b1;
                        if (r_row == r_hy) begin
                            r_busy <= 1'b0;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_out) begin
            o_span_row    <= r_row;
            o_span_left   <= (r_left > r_right) ? r_right : r_left;
            o_span_right  <= (r_left > r_right) ? r_left : r_right;
            o_span_colour <= r_col;
            o_last_span   <= (r_row == r_hy);
        end
    end

endmodule

>>> design/triangle_scanline_span_generator_top.sv
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator_top
// scanline triangle span generator: sorted vertices in, one span per step out
// ----------------------------------------------------------------------------
// A load item (operation 0) sorts the three vertices by y, keeping equal rows
// in input order, and arms the block at the bottom row; it gives no result.
// Each step item (operation 1) then gives one span of the current row, from
// the long edge and the active short edge, ends in order, and moves up a row;
// the top row's span has last_span set. A step while idle is dropped. Items
// pass through a two-entry queue, so the input is taken while a span is being
// computed until the queue is full. In the back end a step is dequeued, then
// for each edge it runs a select step, a multiply step, the shared restoring
// divider over CB quotient bits and a finish step, then an output step, which
// waits while a stalled span still holds the output register. A load is taken
// in the dequeue step and needs no further work.
module triangle_scanline_span_generator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_operation,
    input  logic [tssg_pkg::CB-1:0]    i_ax,
    input  logic [tssg_pkg::CB-1:0]    i_ay,
    input  logic [tssg_pkg::CB-1:0]    i_bx,
    input  logic [tssg_pkg::CB-1:0]    i_by,
    input  logic [tssg_pkg::CB-1:0]    i_cx,
    input  logic [tssg_pkg::CB-1:0]    i_cy,
    input  logic [tssg_pkg::COL_W-1:0] i_colour_a,
    input  logic [tssg_pkg::COL_W-1:0] i_colour_b,
    input  logic [tssg_pkg::COL_W-1:0] i_colour_c,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tssg_pkg::CB-1:0]    o_span_row,
    output logic [tssg_pkg::CB-1:0]    o_span_left,
    output logic [tssg_pkg::CB-1:0]    o_span_right,
    output logic [tssg_pkg::COL_W-1:0] o_span_colour,
    output logic                       o_last_span
);
    import tssg_pkg::*;

    t_cmd front_cmd, q_cmd;
    logic q_full, q_avail, q_pop;

    // front: sort on the way in
    tssg_front u_front (
        .i_operation (i_operation),
        .i_ax (i_ax), .i_ay (i_ay),
        .i_bx (i_bx), .i_by (i_by),
        .i_cx (i_cx), .i_cy (i_cy),
        .i_colour_a (i_colour_a),
        .i_colour_b (i_colour_b),
        .i_colour_c (i_colour_c),
        .o_cmd (front_cmd)
    );

    // stall only when the queue is full
    assign o_stall = q_full;

    tssg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_cmd   (q_cmd)
    );

    // back: triangle state, interpolation and output register
    tssg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (q_avail),
        .i_cmd         (q_cmd),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_span_row    (o_span_row),
        .o_span_left   (o_span_left),
        .o_span_right  (o_span_right),
        .o_span_colour (o_span_colour),
        .o_last_span   (o_last_span)
    );

endmodule

>>> design/tssg_checker.sv
// ----------------------------------------------------------------------------
// tssg_checker
// port-level checks of the span generator, bound to the top level
// ----------------------------------------------------------------------------
module tssg_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [tssg_pkg::CB-1:0]    o_span_row,
    input logic [tssg_pkg::CB-1:0]    o_span_left,
    input logic [tssg_pkg::CB-1:0]    o_span_right,
    input logic [tssg_pkg::COL_W-1:0] o_span_colour
);
    import tssg_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("span item dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_span_row) && $stable(o_span_left)
            && $stable(o_span_right) && $stable(o_span_colour))
        else $error("stalled span item changed");

    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_span_left <= o_span_right)
        else $error("span ends out of order");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("span item right after reset");

endmodule

bind triangle_scanline_span_generator_top tssg_checker u_tssg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_span_row    (o_span_row),
    .o_span_left   (o_span_left),
    .o_span_right  (o_span_right),
    .o_span_colour (o_span_colour)
);
